// ----- rtl/core/sidl_pkg.sv -----
package sidl_pkg;

   // role codes of one result beat
   localparam logic [2:0] ROLE_LIST_SIZE = 3'd0;
   localparam logic [2:0] ROLE_ITEM_SIZE = 3'd1;
   localparam logic [2:0] ROLE_ITEM_DATA = 3'd2;
   localparam logic [2:0] ROLE_TERMINAL  = 3'd3;
   localparam logic [2:0] ROLE_IGNORED   = 3'd4;

   // size of a list or item size header in bytes
   localparam logic [15:0] HDR_BYTES = 16'd2;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       first_byte;
   } beat_type;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [14:0] item_number;
      logic [15:0] data_offset;
      logic        item_end;
      logic        list_done;
      logic        format_error;
   } result_type;

endpackage

// ----- rtl/core/sidl_in_stage.sv -----
module sidl_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_stall,
   input  sidl_pkg::beat_type  up_beat,
   output logic                down_valid,
   input  logic                down_stall,
   output sidl_pkg::beat_type  down_beat
);
   import sidl_pkg::*;

   logic     valid_ff;
   beat_type beat_ff;
   logic     load;

   // stage moves whenever it is empty or its beat leaves this cycle
   assign load     = !(valid_ff && down_stall);
   assign up_stall = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         beat_ff <= up_beat;
      end
   end

   assign down_valid = valid_ff;
   assign down_beat  = beat_ff;

endmodule

// ----- rtl/core/sidl_parse.sv -----
module sidl_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  sidl_pkg::beat_type   in_beat,
   output logic                 out_valid,
   input  logic                 out_stall,
   output sidl_pkg::result_type out_result
);
   import sidl_pkg::*;

   typedef enum logic [2:0] {
      PH_LSIZE_LO,
      PH_LSIZE_HI,
      PH_ISIZE_LO,
      PH_ISIZE_HI,
      PH_DATA,
      PH_TERM_LO,
      PH_TERM_HI,
      PH_DONE
   } phase_type;

   phase_type          phase_ff, phase_in, phase_cur;
   logic [7:0]         low_ff, low_in, low_cur;
   logic signed [16:0] budget_ff, budget_in, budget_cur;
   logic [15:0]        left_ff, left_in, left_cur;
   logic [15:0]        pos_ff, pos_in, pos_cur;
   logic [14:0]        count_ff, count_in, count_cur;
   logic               err_ff, err_in, err_cur;
   logic               out_valid_ff;
   result_type         result_ff, result_in;
   logic               take;
   logic [15:0]        word;
   logic               too_big;

   assign in_stall = out_valid_ff && out_stall;
   assign take     = in_valid && !in_stall;
   assign word     = {in_beat.byte_value, low_cur};
   assign too_big  = $signed({2'b00, word}) > $signed({budget_cur[16], budget_cur});

   always_comb begin
      // first byte of a list restarts from the cleared state
      if (in_beat.first_byte) begin
         phase_cur  = PH_LSIZE_LO;
         low_cur    = 8'd0;
         budget_cur = 17'sd0;
         left_cur   = 16'd0;
         pos_cur    = 16'd0;
         count_cur  = 15'd0;
         err_cur    = 1'b0;
      end else begin
         phase_cur  = phase_ff;
         low_cur    = low_ff;
         budget_cur = budget_ff;
         left_cur   = left_ff;
         pos_cur    = pos_ff;
         count_cur  = count_ff;
         err_cur    = err_ff;
      end

      phase_in  = phase_cur;
      low_in    = low_cur;
      budget_in = budget_cur;
      left_in   = left_cur;
      pos_in    = pos_cur;
      count_in  = count_cur;
      err_in    = err_cur;

      result_in.byte_role   = ROLE_IGNORED;
      result_in.item_number = count_cur;
      result_in.data_offset = 16'd0;
      result_in.item_end    = 1'b0;
      result_in.list_done   = 1'b0;

      unique case (phase_cur)
         PH_LSIZE_LO: begin
            result_in.byte_role = ROLE_LIST_SIZE;
            low_in              = in_beat.byte_value;
            phase_in            = PH_LSIZE_HI;
         end
         PH_LSIZE_HI: begin
            result_in.byte_role = ROLE_LIST_SIZE;
            budget_in = $signed({1'b0, word}) - $signed({1'b0, HDR_BYTES});
            phase_in  = (budget_in > 17'sd0) ? PH_ISIZE_LO : PH_TERM_LO;
         end
         PH_ISIZE_LO: begin
            result_in.byte_role = ROLE_ITEM_SIZE;
            low_in              = in_beat.byte_value;
            phase_in            = PH_ISIZE_HI;
         end
         PH_ISIZE_HI: begin
            result_in.byte_role = ROLE_ITEM_SIZE;
            if (word < HDR_BYTES || too_big) begin
               err_in   = 1'b1;
               phase_in = PH_TERM_LO;
            end else begin
               budget_in = budget_cur - $signed({1'b0, word});
               left_in   = word - HDR_BYTES;
               pos_in    = 16'd0;
               if (word == HDR_BYTES) begin
                  result_in.item_end = 1'b1;
                  count_in = count_cur + 15'd1;
                  phase_in = (budget_in > 17'sd0) ? PH_ISIZE_LO : PH_TERM_LO;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            result_in.byte_role   = ROLE_ITEM_DATA;
            result_in.data_offset = pos_cur;
            pos_in  = pos_cur + 16'd1;
            left_in = left_cur - 16'd1;
            if (left_cur == 16'd1) begin
               result_in.item_end = 1'b1;
               count_in = count_cur + 15'd1;
               phase_in = (budget_cur > 17'sd0) ? PH_ISIZE_LO : PH_TERM_LO;
            end
         end
         PH_TERM_LO: begin
            result_in.byte_role = ROLE_TERMINAL;
            phase_in            = PH_TERM_HI;
         end
         PH_TERM_HI: begin
            result_in.byte_role = ROLE_TERMINAL;
            result_in.list_done = 1'b1;
            phase_in            = PH_DONE;
         end
         default: begin
            result_in.byte_role = ROLE_IGNORED;
         end
      endcase

      result_in.format_error = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LSIZE_LO;
         low_ff       <= 8'd0;
         budget_ff    <= 17'sd0;
         left_ff      <= 16'd0;
         pos_ff       <= 16'd0;
         count_ff     <= 15'd0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff  <= phase_in;
            low_ff    <= low_in;
            budget_ff <= budget_in;
            left_ff   <= left_in;
            pos_ff    <= pos_in;
            count_ff  <= count_in;
            err_ff    <= err_in;
         end
         if (!in_stall) begin
            out_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

// ----- rtl/core/shell_id_list_deframer.sv -----
// path: a beat accepted into the input register moves on into the result register
// when the parser takes it, and rsp_ takes it from the result register
// throughput: one byte per cycle while rsp_ does not stall, one parse step per byte
// stalls on rsp_ back up through the input register and then onto req_stall
// reset (synchronous, active high) empties both registers and returns the parser
// to the list size low byte with all counters and the error flag cleared
module shell_id_list_deframer (
   input  logic        clock,
   input  logic        reset,
   // request channel: one raw byte per beat
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_first_byte,
   // response channel: one classification per byte
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_byte_role,
   output logic [14:0] rsp_item_number,
   output logic [15:0] rsp_data_offset,
   output logic        rsp_item_end,
   output logic        rsp_list_done,
   output logic        rsp_format_error
);
   import sidl_pkg::*;

   beat_type   req_beat;
   beat_type   stage_beat;
   logic       stage_valid;
   logic       stage_stall;
   result_type rsp_result;

   assign req_beat.byte_value = req_byte_value;
   assign req_beat.first_byte = req_first_byte;

   // input register: decouples req_stall timing from the parse logic
   sidl_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_stall   (req_stall),
      .up_beat    (req_beat),
      .down_valid (stage_valid),
      .down_stall (stage_stall),
      .down_beat  (stage_beat)
   );

   // parse state update and result register; state moves only when a beat
   // enters the result register
   sidl_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stage_valid),
      .in_stall   (stage_stall),
      .in_beat    (stage_beat),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (rsp_result)
   );

   assign rsp_byte_role    = rsp_result.byte_role;
   assign rsp_item_number  = rsp_result.item_number;
   assign rsp_data_offset  = rsp_result.data_offset;
   assign rsp_item_end     = rsp_result.item_end;
   assign rsp_list_done    = rsp_result.list_done;
   assign rsp_format_error = rsp_result.format_error;

endmodule

// ----- rtl/core/sidl_checker.sv -----
module sidl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_byte_role,
   input logic [14:0] rsp_item_number,
   input logic [15:0] rsp_data_offset,
   input logic        rsp_item_end,
   input logic        rsp_list_done,
   input logic        rsp_format_error
);
   import sidl_pkg::*;

   // a stalled result beat stays valid and holds its role, item number, offset and error flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_role)
         && $stable(rsp_item_number) && $stable(rsp_data_offset)
         && $stable(rsp_format_error))
      else $error("stalled response beat changed");

   // list done only on a terminal byte
   a_done_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_done |-> rsp_byte_role == ROLE_TERMINAL)
      else $error("list done on non-terminal byte");

   // an item ends only on its size high byte or its last data byte
   a_end_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_end |->
         rsp_byte_role == ROLE_ITEM_SIZE || rsp_byte_role == ROLE_ITEM_DATA)
      else $error("item end on wrong role");

   // offsets are only reported for data bytes
   a_offset_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_offset != 16'd0 |-> rsp_byte_role == ROLE_ITEM_DATA)
      else $error("data offset on non-data byte");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind shell_id_list_deframer sidl_checker u_sidl_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import sidl_pkg::*;

   typedef logic [7:0] byte_q_type[$];

   // shape of one generated list stream
   typedef enum int {
      SHAPE_CLEAN,      // sizes add up, terminal bytes close the list
      SHAPE_BAD_SIZE,   // one item size below 2 or beyond the remaining budget
      SHAPE_SLACK,      // list size larger than the items, terminal read as a size
      SHAPE_TRUNCATED   // stream cut short, next list restarts mid-parse
   } list_shape_type;

   localparam int RANDOM_BEATS = 950;
   localparam int QUIET_LIMIT  = 2000;   // cycles with no beat on either side
   localparam int DRAIN_CYCLES = 8;      // idle cycles waited after the last expected result, for strays

   // ---------------------------------------------------------------------------
   // id list parse tracker: mirrors the deframer state and queues the
   // classification that each accepted byte must produce
   // ---------------------------------------------------------------------------
   class deframer_scoreboard;
      typedef enum logic [2:0] {
         AT_LIST_LO, AT_LIST_HI, AT_SIZE_LO, AT_SIZE_HI,
         AT_DATA, AT_TERM_LO, AT_TERM_HI, AT_DONE
      } parse_phase_type;

      parse_phase_type    phase;
      logic [7:0]         low_hold;
      logic signed [16:0] budget;
      logic [15:0]        data_left;
      logic [15:0]        data_pos;
      logic [14:0]        items_seen;
      logic               error_flag;
      result_type         expected_q[$];
      int                 failures;
      int                 sent_beats;

      function new();
         restart();
         failures = 0;
         sent_beats = 0;
      endfunction

      function void restart();
         phase = AT_LIST_LO;
         low_hold = '0;
         budget = '0;
         data_left = '0;
         data_pos = '0;
         items_seen = '0;
         error_flag = 1'b0;
      endfunction

      function parse_phase_type phase_after_item();
         return (budget > 0) ? AT_SIZE_LO : AT_TERM_LO;
      endfunction

      function void note_beat(logic [7:0] value, logic first);
         result_type        r;
         logic [15:0]       word;
         logic signed [16:0] sword;
         if (first) restart();
         r = '0;
         r.byte_role = ROLE_IGNORED;
         r.item_number = items_seen;
         word = {value, low_hold};
         sword = $signed({1'b0, word});
         case (phase)
            AT_LIST_LO: begin
               r.byte_role = ROLE_LIST_SIZE;
               low_hold = value;
               phase = AT_LIST_HI;
            end
            AT_LIST_HI: begin
               r.byte_role = ROLE_LIST_SIZE;
               budget = sword - $signed({1'b0, HDR_BYTES});
               phase = phase_after_item();
            end
            AT_SIZE_LO: begin
               r.byte_role = ROLE_ITEM_SIZE;
               low_hold = value;
               phase = AT_SIZE_HI;
            end
            AT_SIZE_HI: begin
               r.byte_role = ROLE_ITEM_SIZE;
               if (word < HDR_BYTES || sword > budget) begin
                  error_flag = 1'b1;
                  phase = AT_TERM_LO;
               end else begin
                  budget = budget - sword;
                  data_left = word - HDR_BYTES;
                  data_pos = '0;
                  if (data_left == 0) begin
                     r.item_end = 1'b1;
                     items_seen = items_seen + 15'd1;
                     phase = phase_after_item();
                  end else begin
                     phase = AT_DATA;
                  end
               end
            end
            AT_DATA: begin
               r.byte_role = ROLE_ITEM_DATA;
               r.data_offset = data_pos;
               data_pos = data_pos + 16'd1;
               data_left = data_left - 16'd1;
               if (data_left == 0) begin
                  r.item_end = 1'b1;
                  items_seen = items_seen + 15'd1;
                  phase = phase_after_item();
               end
            end
            AT_TERM_LO: begin
               r.byte_role = ROLE_TERMINAL;
               phase = AT_TERM_HI;
            end
            AT_TERM_HI: begin
               r.byte_role = ROLE_TERMINAL;
               r.list_done = 1'b1;
               phase = AT_DONE;
            end
            default: begin
            end
         endcase
         r.format_error = error_flag;
         sent_beats++;
         expected_q = {expected_q, r};
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing pending: role %0d", got.byte_role);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("byte_role", want.byte_role, got.byte_role);
         compare_field("item_number", want.item_number, got.item_number);
         compare_field("data_offset", want.data_offset, got.data_offset);
         compare_field("item_end", want.item_end, got.item_end);
         compare_field("list_done", want.list_done, got.list_done);
         compare_field("format_error", want.format_error, got.format_error);
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // clock, reset and block
   // ---------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = '0;
   logic        req_first_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_byte_role;
   logic [14:0] rsp_item_number;
   logic [15:0] rsp_data_offset;
   logic        rsp_item_end;
   logic        rsp_list_done;
   logic        rsp_format_error;

   bit req_eager = 1'b0;   // sender runs back to back while set
   bit rsp_eager = 1'b0;   // receiver never stalls while set
   int quiet_cycles = 0;

   deframer_scoreboard board = new();

   always #10 clock = ~clock;

   shell_id_list_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_value   (req_byte_value),
      .req_first_byte   (req_first_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_role    (rsp_byte_role),
      .rsp_item_number  (rsp_item_number),
      .rsp_data_offset  (rsp_data_offset),
      .rsp_item_end     (rsp_item_end),
      .rsp_list_done    (rsp_list_done),
      .rsp_format_error (rsp_format_error)
   );

   // ---------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------

   // one byte beat: optional idle gap, then hold the payload until accepted;
   // signals are sampled right after the edge, before any register update lands
   task automatic send_beat(input logic [7:0] value, input logic first);
      int unsigned gap;
      gap = req_eager ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= value;
      req_first_byte <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_beat(value, first);
   endtask

   // whole stream, first byte flagged as the start of a list
   task automatic send_stream(input byte_q_type s);
      foreach (s[i]) send_beat(s[i], i == 0);
   endtask

   // little-endian 16-bit field
   function automatic void add_word(ref byte_q_type s, input logic [15:0] w);
      s = {s, w[7:0], w[15:8]};
   endfunction

   // mostly small items, now and then one a few hundred bytes long
   task automatic send_list(input list_shape_type shape);
      byte_q_type  s;
      int unsigned sizes[$];
      int unsigned total, extra, rem, bad_at, sz;
      total = 2;
      repeat ($urandom_range(0, 5)) begin
         sz = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 600) : $urandom_range(2, 9);
         sizes = {sizes, sz};
         total += sz;
      end
      // room in the budget so the bad size or the slack is actually parsed
      extra = 0;
      if (shape == SHAPE_BAD_SIZE) extra = $urandom_range(2, 40);
      else if (shape == SHAPE_SLACK) extra = $urandom_range(1, 6);
      bad_at = (shape == SHAPE_BAD_SIZE) ? $urandom_range(0, sizes.size()) : sizes.size();
      add_word(s, 16'(total + extra));
      rem = total - 2 + extra;
      for (int i = 0; i < bad_at; i++) begin
         add_word(s, 16'(sizes[i]));
         repeat (sizes[i] - 2) s = {s, 8'($urandom_range(0, 255))};
         rem -= sizes[i];
      end
      // undersized or oversized item size, half and half
      if (shape == SHAPE_BAD_SIZE) begin
         if ($urandom_range(0, 1) == 0) add_word(s, 16'($urandom_range(0, 1)));
         else add_word(s, 16'($urandom_range(rem + 1, 65535)));
      end
      // terminal bytes carry no meaning, then a few bytes the parser ignores
      add_word(s, 16'($urandom));
      repeat ($urandom_range(0, 2)) s = {s, 8'($urandom)};
      if (shape == SHAPE_TRUNCATED)
         repeat ($urandom_range(1, s.size() - 1)) void'(s.pop_back());
      send_stream(s);
   endtask

   // ---------------------------------------------------------------------------
   // receiver side: random stall before each result, with no-stall stretches
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_eager = !rsp_eager;
         gap = rsp_eager ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // result monitor: every accepted beat is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_byte_role, rsp_item_number, rsp_data_offset,
                             rsp_item_end, rsp_list_done, rsp_format_error});
   end

   // watchdog: a long stretch without any beat means the block hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("shell_id_list_deframer verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // list size below 2: straight to terminal, then a byte ignored after done
      send_stream({8'h01, 8'h00, 8'h5a, 8'ha5, 8'hff});
      // two empty items: item end lands on the size high byte
      send_stream({8'h06, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00, 8'hff});
      // largest list size, undersized item, cut off by a restart
      send_stream({8'hff, 8'hff, 8'h01, 8'h00});
      // one data byte item, then an oversized item hits the error path
      send_stream({8'h07, 8'h00, 8'h03, 8'h00, 8'haa, 8'hff, 8'hff, 8'h00, 8'h00});

      // random part: mostly well-formed lists, the rest broken or noise
      while (board.sent_beats < RANDOM_BEATS) begin
         req_eager = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick <= 5) send_list(SHAPE_CLEAN);
         else if (pick == 6) send_list(SHAPE_BAD_SIZE);
         else if (pick == 7) send_list(SHAPE_SLACK);
         else if (pick == 8) send_list(SHAPE_TRUNCATED);
         else
            repeat ($urandom_range(1, 8))
               send_beat(8'($urandom), $urandom_range(0, 7) == 0);
      end
      req_valid <= 1'b0;

      // drain: all results back, then a few more cycles for strays
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.failures == 0)
         $display("shell_id_list_deframer verification clean");
      else
         $display("shell_id_list_deframer verification failed");
      $finish;
   end

endmodule
